// ===== design/twc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package twc_pkg;

  // Event codes
  localparam logic [2:0] MODE_REG_WRITE = 3'd0;
  localparam logic [2:0] MODE_ENABLE    = 3'd1;
  localparam logic [2:0] MODE_TIMER     = 3'd2;
  localparam logic [2:0] MODE_QUARTER   = 3'd3;
  localparam logic [2:0] MODE_HALF      = 3'd4;

  // Register offsets
  localparam logic [1:0] REG_CONTROL  = 2'd0;
  localparam logic [1:0] REG_UNUSED   = 2'd1;
  localparam logic [1:0] REG_TIMER_LO = 2'd2;
  localparam logic [1:0] REG_TIMER_HI = 2'd3;

  // Timer advance saturation
  localparam logic [4:0] MAX_TICKS = 5'd16;

  // Restoring divider: one quotient bit per cycle over the 12-bit sum
  localparam int DIVIDEND_W = 12;
  localparam int DIV_CNT_W  = 4;
  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIVIDEND_W - 1);

  // Length load values, indexed by the upper five bits of the written byte
  localparam logic [7:0] LENGTH_TABLE [32] = '{
    8'h0A, 8'hFE, 8'h14, 8'h02, 8'h28, 8'h04, 8'h50, 8'h06,
    8'hA0, 8'h08, 8'h3C, 8'h0A, 8'h0E, 8'h0C, 8'h1A, 8'h0E,
    8'h0C, 8'h10, 8'h18, 8'h12, 8'h30, 8'h14, 8'h60, 8'h16,
    8'hC0, 8'h18, 8'h48, 8'h1A, 8'h10, 8'h1C, 8'h20, 8'h1E
  };

  // Controller to datapath
  typedef struct packed {
    logic accept;    // apply the event on the channel now
    logic div_step;  // run one divider iteration
    logic out_load;  // capture the result into the output register
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic div_needed;  // event is a timer advance with a nonzero period
    logic div_last;    // divider is on its final iteration
  } dp_status_t;

endpackage

`default_nettype wire

// ===== design/twc_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface twc_evt_if;
  logic       valid;
  logic       ready;
  logic [2:0] mode;
  logic [1:0] reg_index;
  logic [7:0] reg_value;
  logic       enable_flag;
  logic [4:0] tick_count;

  modport source (output valid, mode, reg_index, reg_value, enable_flag, tick_count,
                  input ready);
  modport sink   (input valid, mode, reg_index, reg_value, enable_flag, tick_count,
                  output ready);
endinterface

interface twc_res_if;
  logic       valid;
  logic       ready;
  logic [4:0] sequence_step;
  logic       sample_active;
  logic       length_active;

  modport source (output valid, sequence_step, sample_active, length_active,
                  input ready);
  modport sink   (input valid, sequence_step, sample_active, length_active,
                  output ready);
endinterface

`default_nettype wire

// ===== design/twc_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module twc_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  input  wire twc_pkg::dp_status_t   status,
  output twc_pkg::ctrl_cmd_t         cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_RESP = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       out_valid_next;
  logic       accept;
  logic       out_free;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  // Issue commands
  always_comb begin
    cmd.accept   = accept;
    cmd.div_step = (state == ST_DIV);
    cmd.out_load = (state == ST_RESP) && out_free;
  end

  // Sequence one item: apply, divide if needed, then post the result
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = status.div_needed ? ST_DIV : ST_RESP;
        end
      end
      ST_DIV: begin
        if (status.div_last) begin
          state_next = ST_RESP;
        end
      end
      ST_RESP: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Track the output register occupancy
  always_comb begin
    out_valid_next = out_valid;
    if (out_valid && out_ready) begin
      out_valid_next = 1'b0;
    end
    if (cmd.out_load) begin
      out_valid_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

`default_nettype wire

// ===== design/twc_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module twc_datapath (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire twc_pkg::ctrl_cmd_t  cmd,
  input  wire logic [2:0]          mode,
  input  wire logic [1:0]          reg_index,
  input  wire logic [7:0]          reg_value,
  input  wire logic                enable_flag,
  input  wire logic [4:0]          tick_count,
  output twc_pkg::dp_status_t      status,
  output logic [4:0]               sequence_step,
  output logic                     sample_active,
  output logic                     length_active
);

  // Channel state
  logic [10:0] timer_count;
  logic [10:0] timer_period;
  logic [4:0]  step_position;
  logic [7:0]  length_count;
  logic [6:0]  linear_count;
  logic [6:0]  linear_reload_value;
  logic        control_bit;
  logic        reload_pending;
  logic        channel_on;
  logic        length_clock_enable;

  // Divider registers
  logic [twc_pkg::DIVIDEND_W-1:0] div_dividend;
  logic [10:0]                    div_rem;
  logic [3:0]                     div_quot;
  logic [twc_pkg::DIV_CNT_W-1:0]  div_cnt;

  logic [4:0]                     ticks_sat;
  logic [twc_pkg::DIVIDEND_W-1:0] total;
  logic [twc_pkg::DIVIDEND_W-1:0] shifted;
  logic [twc_pkg::DIVIDEND_W-1:0] period_ext;
  logic [twc_pkg::DIVIDEND_W-1:0] rem_new;
  logic                           quot_bit;
  logic                           seq_gate;

  // Saturate the tick count and form the dividend
  assign ticks_sat  = (tick_count > twc_pkg::MAX_TICKS) ? twc_pkg::MAX_TICKS : tick_count;
  assign total      = {1'b0, timer_count} + {7'b0, ticks_sat};

  // One restoring-division step
  assign shifted    = {div_rem, div_dividend[twc_pkg::DIVIDEND_W-1]};
  assign period_ext = {1'b0, timer_period};
  assign quot_bit   = (shifted >= period_ext);
  assign rem_new    = quot_bit ? (shifted - period_ext) : shifted;

  assign seq_gate   = channel_on && (length_count != 8'd0) && (linear_count != 7'd0);

  always_comb begin
    status.div_needed = (mode == twc_pkg::MODE_TIMER) && (timer_period != 11'd0);
    status.div_last   = (div_cnt == twc_pkg::DIV_LAST);
  end

  // Apply events and commit the timer advance
  always_ff @(posedge clk) begin
    if (rst) begin
      timer_count         <= 11'd0;
      timer_period        <= 11'd0;
      step_position       <= 5'd0;
      length_count        <= 8'd0;
      linear_count        <= 7'd0;
      linear_reload_value <= 7'd0;
      control_bit         <= 1'b0;
      reload_pending      <= 1'b1;
      channel_on          <= 1'b0;
      length_clock_enable <= 1'b0;
    end else if (cmd.accept) begin
      case (mode)
        twc_pkg::MODE_REG_WRITE: begin
          case (reg_index)
            twc_pkg::REG_CONTROL: begin
              control_bit         <= reg_value[7];
              linear_reload_value <= reg_value[6:0];
              length_clock_enable <= !reg_value[7];
            end
            twc_pkg::REG_TIMER_LO: begin
              timer_period[7:0] <= reg_value;
            end
            twc_pkg::REG_TIMER_HI: begin
              timer_period[10:8] <= reg_value[2:0];
              length_count       <= twc_pkg::LENGTH_TABLE[reg_value[7:3]];
              reload_pending     <= 1'b1;
            end
            default: begin
            end
          endcase
        end
        twc_pkg::MODE_ENABLE: begin
          channel_on <= enable_flag;
          if (!enable_flag) begin
            length_count <= 8'd0;
          end
        end
        twc_pkg::MODE_QUARTER: begin
          if (reload_pending) begin
            linear_count <= linear_reload_value;
          end else if (linear_count != 7'd0) begin
            linear_count <= linear_count - 7'd1;
          end
          if (!control_bit) begin
            reload_pending <= 1'b0;
          end
        end
        twc_pkg::MODE_HALF: begin
          if (length_clock_enable && (length_count != 8'd0)) begin
            length_count <= length_count - 8'd1;
          end
        end
        default: begin
        end
      endcase
    end else if (cmd.div_step && status.div_last) begin
      timer_count <= rem_new[10:0];
      if (seq_gate) begin
        step_position <= step_position + {div_quot, quot_bit};
      end
    end
  end

  // Load and iterate the divider
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      div_dividend <= total;
      div_rem      <= 11'd0;
      div_quot     <= 4'd0;
      div_cnt      <= '0;
    end else if (cmd.div_step) begin
      div_dividend <= {div_dividend[twc_pkg::DIVIDEND_W-2:0], 1'b0};
      div_rem      <= rem_new[10:0];
      div_quot     <= {div_quot[2:0], quot_bit};
      div_cnt      <= div_cnt + twc_pkg::DIV_CNT_W'(1);
    end
  end

  // Capture the result
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      sequence_step <= step_position;
      sample_active <= channel_on && (timer_period > 11'd7) &&
                       (linear_count != 7'd0) && (length_count != 8'd0);
      length_active <= channel_on && (length_count != 8'd0);
    end
  end

endmodule

`default_nettype wire

// ===== design/triangle_wave_channel.sv =====
// Triangle channel: one result item per event item.
// Register, enable and frame events go straight to the result state after accept;
//   a timer advance with a nonzero period first runs the 12-step restoring divider.
// One item at a time: a new item is taken only after the last result is loaded; a
//   waiting result does not block acceptance of the next item.
// Reset (rst, synchronous): channel state clears, linear reload flag set.
`timescale 1ns / 1ps
`default_nettype none

module triangle_wave_channel (
  input  wire logic  clk,
  input  wire logic  rst,
  twc_evt_if.sink    evt,
  twc_res_if.source  res
);

  twc_pkg::ctrl_cmd_t  cmd;
  twc_pkg::dp_status_t status;

  twc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (evt.valid),
    .in_ready  (evt.ready),
    .out_valid (res.valid),
    .out_ready (res.ready),
    .status    (status),
    .cmd       (cmd)
  );

  twc_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .mode          (evt.mode),
    .reg_index     (evt.reg_index),
    .reg_value     (evt.reg_value),
    .enable_flag   (evt.enable_flag),
    .tick_count    (evt.tick_count),
    .status        (status),
    .sequence_step (res.sequence_step),
    .sample_active (res.sample_active),
    .length_active (res.length_active)
  );

  // Never take an item while the divider runs
  a_no_accept_in_div: assert property (@(posedge clk) disable iff (rst)
    !(cmd.div_step && evt.ready))
    else $error("item accepted during division");

  // Load a result only into a free output register
  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!res.valid || res.ready))
    else $error("result overwrote a pending item");

  // One item in flight at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (evt.valid && evt.ready) |=> !evt.ready)
    else $error("second item accepted before result posted");

  // Every accepted item moves on to division or to the result state
  a_accept_to_work: assert property (@(posedge clk) disable iff (rst)
    (evt.valid && evt.ready) |=> (cmd.div_step || !evt.ready))
    else $error("accepted item not processed");

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;

  // Event codes the block leaves undefined
  localparam logic [2:0] MODE_RESERVED_FIRST = 3'd5;
  localparam logic [2:0] MODE_RESERVED_LAST  = 3'd7;

  localparam int RANDOM_ITEMS = 1000;
  localparam int DRAIN_CYCLES = 40;

  // Length counter load values, indexed by the upper five bits of the byte
  localparam logic [7:0] LENGTH_LOAD [32] = '{
    8'h0A, 8'hFE, 8'h14, 8'h02, 8'h28, 8'h04, 8'h50, 8'h06,
    8'hA0, 8'h08, 8'h3C, 8'h0A, 8'h0E, 8'h0C, 8'h1A, 8'h0E,
    8'h0C, 8'h10, 8'h18, 8'h12, 8'h30, 8'h14, 8'h60, 8'h16,
    8'hC0, 8'h18, 8'h48, 8'h1A, 8'h10, 8'h1C, 8'h20, 8'h1E
  };

  typedef struct packed {
    logic [4:0] step;
    logic       sample_on;
    logic       length_on;
  } wave_out_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  always #1 clk = ~clk;

  twc_evt_if evt_if ();
  twc_res_if res_if ();

  triangle_wave_channel u_top (
    .clk (clk),
    .rst (rst),
    .evt (evt_if),
    .res (res_if)
  );

  // Channel model state
  logic [10:0] ch_timer_count;
  logic [10:0] ch_period;
  logic [4:0]  ch_step;
  logic [7:0]  ch_length;
  logic [6:0]  ch_linear;
  logic [6:0]  ch_linear_reload;
  logic        ch_control;
  logic        ch_reload_flag;
  logic        ch_enabled;
  logic        ch_length_clk;

  wave_out_t wave_q [$];
  bit        failed = 1'b0;
  int        burst_left = 0;

  // Receiver stall pattern state
  int          sink_style = 0;
  int          sink_phase_left = 0;
  int unsigned sink_tick = 0;

  task automatic clear_channel_model();
    ch_timer_count   = '0;
    ch_period        = '0;
    ch_step          = '0;
    ch_length        = '0;
    ch_linear        = '0;
    ch_linear_reload = '0;
    ch_control       = 1'b0;
    ch_reload_flag   = 1'b1;
    ch_enabled       = 1'b0;
    ch_length_clk    = 1'b0;
  endtask

  // Apply one event to the channel model and queue the state it reports
  task automatic predict_wave(input logic [2:0] mode, input logic [1:0] idx,
                              input logic [7:0] val, input logic en,
                              input logic [4:0] ticks);
    logic [4:0]  t;
    logic [11:0] total;
    logic [11:0] wraps;
    wave_out_t   r;
    case (mode)
      twc_pkg::MODE_REG_WRITE: begin
        case (idx)
          twc_pkg::REG_CONTROL: begin
            ch_control       = val[7];
            ch_linear_reload = val[6:0];
            ch_length_clk    = !val[7];
          end
          twc_pkg::REG_TIMER_LO: ch_period[7:0] = val;
          twc_pkg::REG_TIMER_HI: begin
            ch_period[10:8] = val[2:0];
            ch_length       = LENGTH_LOAD[val[7:3]];
            ch_reload_flag  = 1'b1;
          end
          default: ;
        endcase
      end
      twc_pkg::MODE_ENABLE: begin
        ch_enabled = en;
        if (!en) ch_length = '0;
      end
      twc_pkg::MODE_TIMER: begin
        t = (ticks > twc_pkg::MAX_TICKS) ? twc_pkg::MAX_TICKS : ticks;
        if (ch_period != '0) begin
          total          = {1'b0, ch_timer_count} + 12'(t);
          wraps          = total / {1'b0, ch_period};
          ch_timer_count = 11'(total % {1'b0, ch_period});
          // sequence only moves while the channel is gated on
          if (ch_enabled && ch_length != '0 && ch_linear != '0)
            ch_step = ch_step + wraps[4:0];
        end
      end
      twc_pkg::MODE_QUARTER: begin
        if (ch_reload_flag) ch_linear = ch_linear_reload;
        else if (ch_linear != '0) ch_linear = ch_linear - 7'd1;
        if (!ch_control) ch_reload_flag = 1'b0;
      end
      twc_pkg::MODE_HALF: begin
        if (ch_length_clk && ch_length != '0) ch_length = ch_length - 8'd1;
      end
      default: ;
    endcase
    r.step      = ch_step;
    r.sample_on = ch_enabled && ch_period > 11'd7 && ch_linear != '0 && ch_length != '0;
    r.length_on = ch_enabled && ch_length != '0;
    wave_q.push_back(r);
  endtask

  // Send one event item, with random gaps between bursts
  task automatic issue_event(input logic [2:0] mode, input logic [1:0] idx,
                             input logic [7:0] val, input logic en,
                             input logic [4:0] ticks);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 8);
      @(negedge clk);
      evt_if.valid       = 1'b0;
      evt_if.mode        = 3'($urandom);
      evt_if.reg_index   = 2'($urandom);
      evt_if.reg_value   = 8'($urandom);
      evt_if.enable_flag = 1'($urandom);
      evt_if.tick_count  = 5'($urandom);
      repeat (gap - 1) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
    end
    burst_left--;
    @(negedge clk);
    evt_if.valid       = 1'b1;
    evt_if.mode        = mode;
    evt_if.reg_index   = idx;
    evt_if.reg_value   = val;
    evt_if.enable_flag = en;
    evt_if.tick_count  = ticks;
    do @(posedge clk); while (!evt_if.ready);
    predict_wave(mode, idx, val, en, ticks);
  endtask

  // Receiver: switch between always ready, coin flip and one in four
  always @(negedge clk) begin
    if (sink_phase_left == 0) begin
      sink_style      = $urandom_range(0, 2);
      sink_phase_left = $urandom_range(20, 200);
    end else begin
      sink_phase_left--;
    end
    sink_tick++;
    case (sink_style)
      0:       res_if.ready = 1'b1;
      1:       res_if.ready = 1'($urandom);
      default: res_if.ready = (sink_tick[1:0] == 2'd0);
    endcase
  end

  // Compare each result item against the oldest prediction
  always @(posedge clk) begin : check_wave
    wave_out_t want;
    if (!rst && res_if.valid && res_if.ready) begin
      if (wave_q.size() == 0) begin
        $error("result item with no prediction pending");
        failed = 1'b1;
      end else begin
        want = wave_q.pop_front();
        if (res_if.sequence_step !== want.step) begin
          $error("sequence_step: expected %0d, got %0d", want.step, res_if.sequence_step);
          failed = 1'b1;
        end
        if (res_if.sample_active !== want.sample_on) begin
          $error("sample_active: expected %0d, got %0d", want.sample_on, res_if.sample_active);
          failed = 1'b1;
        end
        if (res_if.length_active !== want.length_on) begin
          $error("length_active: expected %0d, got %0d", want.length_on, res_if.length_active);
          failed = 1'b1;
        end
      end
    end
  end

  // Undefined event, timer advance before any period is set, and a quarter-frame event
  task automatic test_power_on();
    issue_event(MODE_RESERVED_LAST, twc_pkg::REG_TIMER_HI, 8'hFF, 1'b1, 5'd31);
    issue_event(twc_pkg::MODE_TIMER, twc_pkg::REG_CONTROL, 8'h00, 1'b0, 5'd31);
    issue_event(twc_pkg::MODE_QUARTER, twc_pkg::REG_CONTROL, 8'h00, 1'b0, 5'd0);
  endtask

  // Every register written with all ones, halted length counter, saturated ticks
  task automatic test_register_writes();
    issue_event(twc_pkg::MODE_REG_WRITE, twc_pkg::REG_UNUSED, 8'hFF, 1'b1, 5'd31);
    issue_event(twc_pkg::MODE_REG_WRITE, twc_pkg::REG_CONTROL, 8'hFF, 1'b0, 5'd0);
    issue_event(twc_pkg::MODE_REG_WRITE, twc_pkg::REG_TIMER_LO, 8'hFF, 1'b0, 5'd0);
    issue_event(twc_pkg::MODE_REG_WRITE, twc_pkg::REG_TIMER_HI, 8'hFF, 1'b0, 5'd0);
    issue_event(twc_pkg::MODE_ENABLE, twc_pkg::REG_CONTROL, 8'h00, 1'b1, 5'd0);
    issue_event(twc_pkg::MODE_QUARTER, twc_pkg::REG_CONTROL, 8'h00, 1'b0, 5'd0);
    issue_event(twc_pkg::MODE_HALF, twc_pkg::REG_CONTROL, 8'h00, 1'b0, 5'd0);
    issue_event(twc_pkg::MODE_TIMER, twc_pkg::REG_CONTROL, 8'h00, 1'b0, 5'd31);
  endtask

  // Period dropped under the count, then wraps held off by a zero linear count
  task automatic test_sequencer();
    issue_event(twc_pkg::MODE_REG_WRITE, twc_pkg::REG_CONTROL, 8'h00, 1'b0, 5'd0);
    issue_event(twc_pkg::MODE_REG_WRITE, twc_pkg::REG_TIMER_HI, 8'h00, 1'b0, 5'd0);
    issue_event(twc_pkg::MODE_REG_WRITE, twc_pkg::REG_TIMER_LO, 8'h01, 1'b0, 5'd0);
    issue_event(twc_pkg::MODE_TIMER, twc_pkg::REG_CONTROL, 8'h00, 1'b0, 5'd5);
    issue_event(twc_pkg::MODE_QUARTER, twc_pkg::REG_CONTROL, 8'h00, 1'b0, 5'd0);
    issue_event(twc_pkg::MODE_TIMER, twc_pkg::REG_CONTROL, 8'h00, 1'b0, 5'd3);
  endtask

  // Length decrement, clear on disable, linear reload and countdown
  task automatic test_counters();
    issue_event(twc_pkg::MODE_HALF, twc_pkg::REG_CONTROL, 8'h00, 1'b0, 5'd0);
    issue_event(twc_pkg::MODE_ENABLE, twc_pkg::REG_CONTROL, 8'h00, 1'b0, 5'd0);
    issue_event(twc_pkg::MODE_ENABLE, twc_pkg::REG_CONTROL, 8'h00, 1'b1, 5'd0);
    issue_event(MODE_RESERVED_FIRST, twc_pkg::REG_TIMER_LO, 8'h55, 1'b0, 5'd7);
    issue_event(twc_pkg::MODE_REG_WRITE, twc_pkg::REG_CONTROL, 8'h05, 1'b0, 5'd0);
    issue_event(twc_pkg::MODE_REG_WRITE, twc_pkg::REG_TIMER_HI, 8'h08, 1'b0, 5'd0);
    issue_event(twc_pkg::MODE_QUARTER, twc_pkg::REG_CONTROL, 8'h00, 1'b0, 5'd0);
    issue_event(twc_pkg::MODE_REG_WRITE, twc_pkg::REG_TIMER_LO, 8'h08, 1'b0, 5'd0);
    issue_event(twc_pkg::MODE_TIMER, twc_pkg::REG_CONTROL, 8'h00, 1'b0, 5'd16);
    issue_event(twc_pkg::MODE_QUARTER, twc_pkg::REG_CONTROL, 8'h00, 1'b0, 5'd0);
    issue_event(twc_pkg::MODE_HALF, twc_pkg::REG_CONTROL, 8'h00, 1'b0, 5'd0);
  endtask

  // Random events, with an occasional burst that sets up a sounding channel
  task automatic test_random_traffic(input int n_items);
    int         sent;
    int         r;
    logic [7:0] v;
    sent = 0;
    while (sent < n_items) begin
      r = $urandom_range(0, 99);
      if (r < 10) begin
        v = 8'($urandom);
        if ($urandom_range(0, 3) != 0) v[7] = 1'b0;
        issue_event(twc_pkg::MODE_REG_WRITE, twc_pkg::REG_CONTROL, v, 1'($urandom),
                    5'($urandom));
        v = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(0, 40)) : 8'($urandom);
        issue_event(twc_pkg::MODE_REG_WRITE, twc_pkg::REG_TIMER_LO, v, 1'($urandom),
                    5'($urandom));
        v = 8'($urandom);
        if ($urandom_range(0, 9) < 7) v[2:0] = 3'd0;
        issue_event(twc_pkg::MODE_REG_WRITE, twc_pkg::REG_TIMER_HI, v, 1'($urandom),
                    5'($urandom));
        issue_event(twc_pkg::MODE_ENABLE, 2'($urandom), 8'($urandom), 1'b1, 5'($urandom));
        issue_event(twc_pkg::MODE_QUARTER, 2'($urandom), 8'($urandom), 1'($urandom),
                    5'($urandom));
        sent += 5;
      end else begin
        if (r < 35)
          issue_event(twc_pkg::MODE_REG_WRITE, 2'($urandom), 8'($urandom), 1'($urandom),
                      5'($urandom));
        else if (r < 42)
          issue_event(twc_pkg::MODE_ENABLE, 2'($urandom), 8'($urandom),
                      ($urandom_range(0, 99) < 85), 5'($urandom));
        else if (r < 72)
          issue_event(twc_pkg::MODE_TIMER, 2'($urandom), 8'($urandom), 1'($urandom),
                      5'($urandom_range(0, 31)));
        else if (r < 84)
          issue_event(twc_pkg::MODE_QUARTER, 2'($urandom), 8'($urandom), 1'($urandom),
                      5'($urandom));
        else if (r < 96)
          issue_event(twc_pkg::MODE_HALF, 2'($urandom), 8'($urandom), 1'($urandom),
                      5'($urandom));
        else
          issue_event(3'($urandom_range(MODE_RESERVED_FIRST, MODE_RESERVED_LAST)),
                      2'($urandom), 8'($urandom), 1'($urandom), 5'($urandom));
        sent++;
      end
    end
  endtask

  initial begin
    evt_if.valid       = 1'b0;
    evt_if.mode        = twc_pkg::MODE_REG_WRITE;
    evt_if.reg_index   = twc_pkg::REG_CONTROL;
    evt_if.reg_value   = 8'h00;
    evt_if.enable_flag = 1'b0;
    evt_if.tick_count  = 5'd0;
    res_if.ready       = 1'b0;
    clear_channel_model();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_power_on();
    test_register_writes();
    test_sequencer();
    test_counters();
    test_random_traffic(RANDOM_ITEMS);

    // drop valid, drain outstanding results, then watch for strays
    @(negedge clk);
    evt_if.valid = 1'b0;
    while (wave_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (!failed) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Hard stop for a hung handshake
  initial begin
    #1_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
